/* rtl/seven_segment_display_frame_builder_top_macros.svh */
// Assertion macros used by the display frame builder back part.
`ifndef SEVEN_SEGMENT_DISPLAY_FRAME_BUILDER_TOP_MACROS_SVH
`define SEVEN_SEGMENT_DISPLAY_FRAME_BUILDER_TOP_MACROS_SVH

// Same-cycle implication, checked on clk, suspended during rst.
`define SSDFB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked on clk, suspended during rst.
`define SSDFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/ssdfb_pkg.sv */
// Types, command codes and tables for the display frame builder.
`timescale 1ns / 1ps
package ssdfb_pkg;

  typedef enum logic [1:0] {
    KIND_DEC    = 2'd0,
    KIND_RAW    = 2'd1,
    KIND_SINGLE = 2'd2,
    KIND_BRIGHT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DATA_CMD,
    ST_ADDR_CMD,
    ST_BYTE0,
    ST_BYTE1,
    ST_BYTE2,
    ST_BYTE3,
    ST_BRIGHT
  } step_t;

  localparam logic [7:0]  CMD_DATA        = 8'h40;
  localparam logic [7:0]  CMD_ADDR        = 8'hC0;
  localparam logic [7:0]  CMD_BRIGHT_BASE = 8'h87;
  localparam logic [7:0]  CMD_DISPLAY_OFF = 8'h80;
  localparam logic [7:0]  DOT_BIT         = 8'h80;
  localparam logic [3:0]  BRIGHT_MAX      = 4'd8;
  localparam logic [13:0] NUM_WRAP        = 14'd10000;

  localparam logic [7:0] SEG_PATTERN [0:9] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
  };

  // One classified request as it waits between the front and the back.
  typedef struct packed {
    kind_t       kind;
    logic [13:0] value;
    logic        sep;
    logic [7:0]  seg_first;
    logic [7:0]  seg_second;
    logic [7:0]  seg_third;
    logic [7:0]  seg_fourth;
    logic [7:0]  bright_cmd;
  } entry_t;

  typedef struct packed {
    logic full;
    logic avail;
  } q_stat_t;

endpackage

/* rtl/ssdfb_front.sv */
// Front part: classify a request and reduce its operands.
`timescale 1ns / 1ps
module ssdfb_front (
  input  logic [1:0]       req_type,
  input  logic [13:0]      number,
  input  logic             separator,
  input  logic [7:0]       seg_first,
  input  logic [7:0]       seg_second,
  input  logic [7:0]       seg_third,
  input  logic [7:0]       seg_fourth,
  input  logic [3:0]       level,
  output ssdfb_pkg::entry_t entry
);

  logic [3:0] lvl_sat;

  always_comb begin
    lvl_sat = (level > ssdfb_pkg::BRIGHT_MAX) ? ssdfb_pkg::BRIGHT_MAX : level;
    entry.kind       = ssdfb_pkg::kind_t'(req_type);
    // number is below twice the wrap, so one compare and subtract is the modulo
    entry.value      = (number >= ssdfb_pkg::NUM_WRAP) ? number - ssdfb_pkg::NUM_WRAP
                                                       : number;
    entry.sep        = separator;
    entry.seg_first  = seg_first;
    entry.seg_second = seg_second;
    entry.seg_third  = seg_third;
    entry.seg_fourth = seg_fourth;
    entry.bright_cmd = (lvl_sat == 4'd0) ? ssdfb_pkg::CMD_DISPLAY_OFF
                                         : ssdfb_pkg::CMD_BRIGHT_BASE + {4'd0, lvl_sat};
  end

endmodule

/* rtl/ssdfb_queue.sv */
// Short queue of classified requests between front and back.
`timescale 1ns / 1ps
module ssdfb_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  ssdfb_pkg::entry_t wr_data,
  input  logic              rd_en,
  output ssdfb_pkg::entry_t rd_data,
  output ssdfb_pkg::q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ssdfb_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign rd_data    = slots[rd_ptr];
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.avail = (count != '0);

endmodule

/* rtl/ssdfb_back.sv */
// Back part: step through the bytes of each request into the output register.
`timescale 1ns / 1ps
`include "seven_segment_display_frame_builder_top_macros.svh"
module ssdfb_back (
  input  logic               clk,
  input  logic               rst,
  input  ssdfb_pkg::entry_t  head,
  input  ssdfb_pkg::q_stat_t qstat,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic [7:0]         frame_byte,
  output logic               start_before,
  output logic               stop_after,
  output logic               last
);

  ssdfb_pkg::step_t  st;
  ssdfb_pkg::step_t  st_next;
  ssdfb_pkg::entry_t cur;
  logic [13:0]       rem;
  logic              out_valid;

  logic        adv;
  logic        is_final;
  logic        take;
  logic [1:0]  place_idx;
  logic [3:0]  digit;
  logic [13:0] rem_rest;
  logic [7:0]  byte_val;
  logic        start_val;
  logic        stop_val;

  // digit value times the decimal place selected for this byte
  function automatic logic [13:0] place_mult(input logic [1:0] idx, input int j);
    logic [13:0] r;
    case (idx)
      2'd0:    r = 14'(1000 * j);
      2'd1:    r = 14'(100 * j);
      2'd2:    r = 14'(10 * j);
      default: r = 14'(j);
    endcase
    return r;
  endfunction

  function automatic ssdfb_pkg::step_t first_step(input ssdfb_pkg::kind_t k);
    return (k == ssdfb_pkg::KIND_BRIGHT) ? ssdfb_pkg::ST_BRIGHT : ssdfb_pkg::ST_DATA_CMD;
  endfunction

  assign adv      = (st != ssdfb_pkg::ST_IDLE) && (!out_valid || pop);
  assign is_final = (st == ssdfb_pkg::ST_BRIGHT) || (st == ssdfb_pkg::ST_BYTE3) ||
                    ((st == ssdfb_pkg::ST_BYTE0) && (cur.kind == ssdfb_pkg::KIND_SINGLE));
  assign take     = qstat.avail && ((st == ssdfb_pkg::ST_IDLE) || (adv && is_final));
  assign q_pop    = take;
  assign empty    = !out_valid;

  // next step
  always_comb begin
    st_next = st;
    case (st)
      ssdfb_pkg::ST_IDLE: begin
        if (take) begin
          st_next = first_step(head.kind);
        end
      end
      ssdfb_pkg::ST_DATA_CMD: if (adv) st_next = ssdfb_pkg::ST_ADDR_CMD;
      ssdfb_pkg::ST_ADDR_CMD: if (adv) st_next = ssdfb_pkg::ST_BYTE0;
      ssdfb_pkg::ST_BYTE0, ssdfb_pkg::ST_BYTE1, ssdfb_pkg::ST_BYTE2,
      ssdfb_pkg::ST_BYTE3, ssdfb_pkg::ST_BRIGHT: begin
        if (adv) begin
          if (is_final) begin
            st_next = take ? first_step(head.kind) : ssdfb_pkg::ST_IDLE;
          end else begin
            case (st)
              ssdfb_pkg::ST_BYTE0: st_next = ssdfb_pkg::ST_BYTE1;
              ssdfb_pkg::ST_BYTE1: st_next = ssdfb_pkg::ST_BYTE2;
              default:             st_next = ssdfb_pkg::ST_BYTE3;
            endcase
          end
        end
      end
      default: st_next = ssdfb_pkg::ST_IDLE;
    endcase
  end

  // decimal digit of the current place: parallel compares against constant multiples
  always_comb begin
    case (st)
      ssdfb_pkg::ST_BYTE1: place_idx = 2'd1;
      ssdfb_pkg::ST_BYTE2: place_idx = 2'd2;
      ssdfb_pkg::ST_BYTE3: place_idx = 2'd3;
      default:             place_idx = 2'd0;
    endcase
    digit    = '0;
    rem_rest = rem;
    for (int j = 1; j < 10; j++) begin
      if (rem >= place_mult(place_idx, j)) begin
        digit    = 4'(j);
        rem_rest = rem - place_mult(place_idx, j);
      end
    end
  end

  // byte and framing for the current step
  always_comb begin
    byte_val  = '0;
    start_val = 1'b0;
    stop_val  = 1'b0;
    case (st)
      ssdfb_pkg::ST_DATA_CMD: begin
        byte_val  = ssdfb_pkg::CMD_DATA;
        start_val = 1'b1;
        stop_val  = 1'b1;
      end
      ssdfb_pkg::ST_ADDR_CMD: begin
        byte_val  = ssdfb_pkg::CMD_ADDR;
        start_val = 1'b1;
      end
      ssdfb_pkg::ST_BYTE0, ssdfb_pkg::ST_BYTE1, ssdfb_pkg::ST_BYTE2,
      ssdfb_pkg::ST_BYTE3: begin
        stop_val = is_final;
        if (cur.kind == ssdfb_pkg::KIND_DEC) begin
          byte_val = ssdfb_pkg::SEG_PATTERN[digit];
          if ((st == ssdfb_pkg::ST_BYTE1) && cur.sep) begin
            byte_val = byte_val | ssdfb_pkg::DOT_BIT;
          end
        end else begin
          case (st)
            ssdfb_pkg::ST_BYTE0: byte_val = cur.seg_first;
            ssdfb_pkg::ST_BYTE1: byte_val = cur.seg_second;
            ssdfb_pkg::ST_BYTE2: byte_val = cur.seg_third;
            default:             byte_val = cur.seg_fourth;
          endcase
        end
      end
      ssdfb_pkg::ST_BRIGHT: begin
        byte_val  = cur.bright_cmd;
        start_val = 1'b1;
        stop_val  = 1'b1;
      end
      default: byte_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ssdfb_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (adv) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= head;
      rem <= head.value;
    end else if (adv && (st inside {ssdfb_pkg::ST_BYTE0, ssdfb_pkg::ST_BYTE1,
                                    ssdfb_pkg::ST_BYTE2, ssdfb_pkg::ST_BYTE3})) begin
      rem <= rem_rest;
    end
    if (adv) begin
      frame_byte   <= byte_val;
      start_before <= start_val;
      stop_after   <= stop_val;
      last         <= is_final;
    end
  end

  `SSDFB_ASSERT_NEXT(a_final_marks_last, adv && is_final, out_valid && last)
  `SSDFB_ASSERT_NEXT(a_inner_not_last, adv && !is_final, !last && st != ssdfb_pkg::ST_IDLE)
  `SSDFB_ASSERT_NEXT(a_idle_picks_up, st == ssdfb_pkg::ST_IDLE && qstat.avail, st != ssdfb_pkg::ST_IDLE)
  `SSDFB_ASSERT_NOW(a_bright_kind, st == ssdfb_pkg::ST_BRIGHT, cur.kind == ssdfb_pkg::KIND_BRIGHT)

endmodule

/* rtl/seven_segment_display_frame_builder_top.sv */
// Top level of the four-digit seven-segment display frame builder.
`timescale 1ns / 1ps
// Turns each display request into the framed command bytes the display
// controller expects, one result item per byte. Decimal and raw requests give
// six items (0x40, 0xC0, four segment bytes), a single-byte request three, a
// brightness request one. Items come out one per cycle from the output
// register while the receiver keeps popping and requests are queued; the input
// side takes a new item every cycle while the request queue (QUEUE_DEPTH
// entries) has room, so classification of later requests overlaps the byte
// stream of earlier ones.
module seven_segment_display_frame_builder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type,
  input  logic [13:0] number,
  input  logic        separator,
  input  logic [7:0]  seg_first,
  input  logic [7:0]  seg_second,
  input  logic [7:0]  seg_third,
  input  logic [7:0]  seg_fourth,
  input  logic [3:0]  level,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  frame_byte,
  output logic        start_before,
  output logic        stop_after,
  output logic        last
);

  ssdfb_pkg::entry_t  front_entry;
  ssdfb_pkg::entry_t  head;
  ssdfb_pkg::q_stat_t qstat;
  logic               q_pop;

  // Classify the request, reduce the number modulo 10000, build brightness cmd.
  ssdfb_front u_front (
    .req_type   (req_type),
    .number     (number),
    .separator  (separator),
    .seg_first  (seg_first),
    .seg_second (seg_second),
    .seg_third  (seg_third),
    .seg_fourth (seg_fourth),
    .level      (level),
    .entry      (front_entry)
  );

  // Hold classified requests so the input side stalls only when this fills.
  ssdfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !qstat.full),
    .wr_data (front_entry),
    .rd_en   (q_pop),
    .rd_data (head),
    .stat    (qstat)
  );

  assign full = qstat.full;

  // Advance through the bytes of each request, one per cycle the output frees.
  ssdfb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .qstat        (qstat),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .frame_byte   (frame_byte),
    .start_before (start_before),
    .stop_after   (stop_after),
    .last         (last)
  );

endmodule

/* sim/display_frame_checker.sv */
// Checker that predicts and compares the framed bytes of each display request.
`timescale 1ns / 1ps
module display_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  req_type,
  input  logic [13:0] number,
  input  logic        separator,
  input  logic [7:0]  seg_first,
  input  logic [7:0]  seg_second,
  input  logic [7:0]  seg_third,
  input  logic [7:0]  seg_fourth,
  input  logic [3:0]  level,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  frame_byte,
  input  logic        start_before,
  input  logic        stop_after,
  input  logic        last,
  output int          mismatch_count,
  output int          frames_due
);

  typedef struct packed {
    logic [7:0] code;
    logic       start_mark;
    logic       stop_mark;
    logic       end_mark;
  } frame_t;

  localparam logic [7:0] DIGIT_SEGS [0:9] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
  };

  frame_t due_frames[$];
  int     errors = 0;

  function automatic frame_t framed(input logic [7:0] code, input logic start_mark,
                                    input logic stop_mark);
    frame_t f;
    f.code       = code;
    f.start_mark = start_mark;
    f.stop_mark  = stop_mark;
    f.end_mark   = 1'b0;
    return f;
  endfunction

  // Expand one request into the byte sequence the controller must see.
  task automatic expand_request(input ssdfb_pkg::kind_t kind, input logic [13:0] num,
                                input logic sep,
                                input logic [7:0] b0, input logic [7:0] b1,
                                input logic [7:0] b2, input logic [7:0] b3,
                                input logic [3:0] lvl_in);
    frame_t     seq[$];
    int         v;
    logic [7:0] hund;
    logic [3:0] lvl;
    v = int'(num) % 10000;
    if (kind != ssdfb_pkg::KIND_BRIGHT) begin
      seq.push_back(framed(ssdfb_pkg::CMD_DATA, 1'b1, 1'b1));
      seq.push_back(framed(ssdfb_pkg::CMD_ADDR, 1'b1, 1'b0));
    end
    case (kind)
      ssdfb_pkg::KIND_DEC: begin
        hund = DIGIT_SEGS[(v / 100) % 10];
        if (sep) hund = hund | ssdfb_pkg::DOT_BIT;
        seq.push_back(framed(DIGIT_SEGS[(v / 1000) % 10], 1'b0, 1'b0));
        seq.push_back(framed(hund, 1'b0, 1'b0));
        seq.push_back(framed(DIGIT_SEGS[(v / 10) % 10], 1'b0, 1'b0));
        seq.push_back(framed(DIGIT_SEGS[v % 10], 1'b0, 1'b1));
      end
      ssdfb_pkg::KIND_RAW: begin
        seq.push_back(framed(b0, 1'b0, 1'b0));
        seq.push_back(framed(b1, 1'b0, 1'b0));
        seq.push_back(framed(b2, 1'b0, 1'b0));
        seq.push_back(framed(b3, 1'b0, 1'b1));
      end
      ssdfb_pkg::KIND_SINGLE: begin
        seq.push_back(framed(b0, 1'b0, 1'b1));
      end
      default: begin
        lvl = (lvl_in > ssdfb_pkg::BRIGHT_MAX) ? ssdfb_pkg::BRIGHT_MAX : lvl_in;
        seq.push_back(framed((lvl == 4'd0) ? ssdfb_pkg::CMD_DISPLAY_OFF
                                           : ssdfb_pkg::CMD_BRIGHT_BASE + 8'(lvl),
                             1'b1, 1'b1));
      end
    endcase
    seq[seq.size() - 1].end_mark = 1'b1;
    foreach (seq[i]) due_frames.push_back(seq[i]);
  endtask

  always @(posedge clk) begin
    frame_t want;
    if (!rst) begin
      // Check the result first: a request taken at this edge cannot show yet.
      if (pop && !empty) begin
        if (due_frames.size() == 0) begin
          $error("unexpected result item: frame_byte 8'h%02h", frame_byte);
          errors++;
        end else begin
          want = due_frames.pop_front();
          if (frame_byte !== want.code) begin
            $error("frame_byte mismatch: expected 8'h%02h, got 8'h%02h", want.code, frame_byte);
            errors++;
          end
          if (start_before !== want.start_mark) begin
            $error("start_before mismatch: expected %0b, got %0b", want.start_mark,
                   start_before);
            errors++;
          end
          if (stop_after !== want.stop_mark) begin
            $error("stop_after mismatch: expected %0b, got %0b", want.stop_mark, stop_after);
            errors++;
          end
          if (last !== want.end_mark) begin
            $error("last mismatch: expected %0b, got %0b", want.end_mark, last);
            errors++;
          end
        end
      end
      if (push && !full)
        expand_request(ssdfb_pkg::kind_t'(req_type), number, separator, seg_first,
                       seg_second, seg_third, seg_fourth, level);
    end
    mismatch_count <= errors;
    frames_due     <= due_frames.size();
  end

endmodule

/* sim/seven_segment_display_frame_builder_top_tb.sv */
// Testbench top: drives display requests and result pops, gives the verdict.
`timescale 1ns / 1ps
module seven_segment_display_frame_builder_top_tb;

  // Cycles with no handshake on either side before the run is declared hung.
  localparam int QUIET_LIMIT = 5000;
  // Cycles to idle after the last result before the verdict is given.
  localparam int TAIL_CYCLES = 16;
  localparam int ITEMS_PER_PHASE = 50;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  req_type = '0;
  logic [13:0] number = '0;
  logic        separator = 1'b0;
  logic [7:0]  seg_first = '0;
  logic [7:0]  seg_second = '0;
  logic [7:0]  seg_third = '0;
  logic [7:0]  seg_fourth = '0;
  logic [3:0]  level = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  frame_byte;
  logic        start_before;
  logic        stop_after;
  logic        last;

  int mismatch_count;
  int frames_due;
  int push_gap_pct = 30;
  int pop_gap_pct = 45;
  int quiet_cycles = 0;

  always #10 clk = ~clk;

  seven_segment_display_frame_builder_top uut (
    .clk, .rst, .push, .full, .req_type, .number, .separator,
    .seg_first, .seg_second, .seg_third, .seg_fourth, .level,
    .empty, .pop, .frame_byte, .start_before, .stop_after, .last
  );

  display_frame_checker frame_check (
    .clk, .rst, .push, .full, .req_type, .number, .separator,
    .seg_first, .seg_second, .seg_third, .seg_fourth, .level,
    .empty, .pop, .frame_byte, .start_before, .stop_after, .last,
    .mismatch_count, .frames_due
  );

  // Stall the result side at random; the rate follows the current phase.
  always @(posedge clk)
    pop <= ($urandom_range(0, 99) >= pop_gap_pct);

  // Watchdog: abort when neither side has moved an item for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Present one request and hold it until the block takes it. Idle cycles
  // before it carry random field values so ignored inputs get exercised too.
  task automatic send_req(input ssdfb_pkg::kind_t kind, input logic [13:0] num,
                          input logic sep,
                          input logic [7:0] b0, input logic [7:0] b1,
                          input logic [7:0] b2, input logic [7:0] b3,
                          input logic [3:0] lvl);
    while ($urandom_range(0, 99) < push_gap_pct) begin
      push       <= 1'b0;
      req_type   <= 2'($urandom);
      number     <= 14'($urandom);
      separator  <= 1'($urandom);
      seg_first  <= 8'($urandom);
      seg_second <= 8'($urandom);
      seg_third  <= 8'($urandom);
      seg_fourth <= 8'($urandom);
      level      <= 4'($urandom);
      @(posedge clk);
    end
    push       <= 1'b1;
    req_type   <= kind;
    number     <= num;
    separator  <= sep;
    seg_first  <= b0;
    seg_second <= b1;
    seg_third  <= b2;
    seg_fourth <= b3;
    level      <= lvl;
    do @(posedge clk); while (full);
  endtask

  // Any request with every field random; brightness levels cover 0..15.
  task automatic send_random();
    send_req(ssdfb_pkg::kind_t'($urandom_range(0, 3)), 14'($urandom_range(0, 16383)),
             1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
  endtask

  // Hold the request side quiet until every predicted byte has been popped.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (frames_due != 0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Decimal: zero, all nines, wrap at 10000, top of range; digits 0..9 seen.
    send_req(ssdfb_pkg::KIND_DEC, 14'd0, 1'b0, 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom), 4'($urandom));
    send_req(ssdfb_pkg::KIND_DEC, 14'd9999, 1'b1, 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom), 4'($urandom));
    send_req(ssdfb_pkg::KIND_DEC, 14'd10000, 1'b0, 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom), 4'($urandom));
    send_req(ssdfb_pkg::KIND_DEC, 14'd16383, 1'b1, 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom), 4'($urandom));
    send_req(ssdfb_pkg::KIND_DEC, 14'd1234, 1'b0, 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom), 4'($urandom));
    send_req(ssdfb_pkg::KIND_DEC, 14'd5678, 1'b1, 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom), 4'($urandom));
    // Raw segments: all clear, all set, mixed bit patterns.
    send_req(ssdfb_pkg::KIND_RAW, 14'($urandom), 1'($urandom), 8'h00, 8'h00, 8'h00, 8'h00,
             4'($urandom));
    send_req(ssdfb_pkg::KIND_RAW, 14'($urandom), 1'($urandom), 8'hff, 8'hff, 8'hff, 8'hff,
             4'($urandom));
    send_req(ssdfb_pkg::KIND_RAW, 14'($urandom), 1'($urandom), 8'h01, 8'h80, 8'h5a, 8'ha5,
             4'($urandom));
    // Single byte at both extremes.
    send_req(ssdfb_pkg::KIND_SINGLE, 14'($urandom), 1'($urandom), 8'h00, 8'($urandom),
             8'($urandom), 8'($urandom), 4'($urandom));
    send_req(ssdfb_pkg::KIND_SINGLE, 14'($urandom), 1'($urandom), 8'hff, 8'($urandom),
             8'($urandom), 8'($urandom), 4'($urandom));
    // Brightness: display off, normal range, top level, and saturation above it.
    send_req(ssdfb_pkg::KIND_BRIGHT, 14'($urandom), 1'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom), 8'($urandom), 4'd0);
    send_req(ssdfb_pkg::KIND_BRIGHT, 14'($urandom), 1'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom), 8'($urandom), 4'd1);
    send_req(ssdfb_pkg::KIND_BRIGHT, 14'($urandom), 1'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom), 8'($urandom), 4'd7);
    send_req(ssdfb_pkg::KIND_BRIGHT, 14'($urandom), 1'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom), 8'($urandom), 4'd8);
    send_req(ssdfb_pkg::KIND_BRIGHT, 14'($urandom), 1'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom), 8'($urandom), 4'd9);
    send_req(ssdfb_pkg::KIND_BRIGHT, 14'($urandom), 1'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom), 8'($urandom), 4'd15);
    drain();

    // Random traffic in three phases: sender-light stalls, receiver-light
    // stalls, then full rate on both sides.
    for (int phase = 0; phase < 3; phase++) begin
      push_gap_pct = (phase == 0) ? 30 : (phase == 1) ? 45 : 0;
      pop_gap_pct  = (phase == 0) ? 45 : (phase == 1) ? 30 : 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_random();
        // Let the pipeline run dry once mid-phase, then restart from empty.
        if (i == ITEMS_PER_PHASE / 2) drain();
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && frames_due == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/ssdfb_pkg.sv
rtl/ssdfb_front.sv
rtl/ssdfb_queue.sv
rtl/ssdfb_back.sv
rtl/seven_segment_display_frame_builder_top.sv
sim/display_frame_checker.sv
sim/seven_segment_display_frame_builder_top_tb.sv
